FILE: design/assert_macros.svh
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_ALWAYS(lbl, !(expr), msg)

`endif

FILE: design/rgbrle_pkg.sv
// Types and constants shared by the RLE encoder modules.
`timescale 1ns / 1ps
package rgbrle_pkg;

  localparam int OFS_W    = 12;
  localparam int COL_W    = 24;
  localparam int CNT_W    = 8;
  localparam int MAX_WR   = 5;
  localparam int WR_IDX_W = 3;

  localparam logic KIND_TAG    = 1'b0;
  localparam logic KIND_COLOUR = 1'b1;

  localparam logic RUN_BIT = 1'b1;
  localparam logic LIT_BIT = 1'b0;

  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic             kind;
    logic [COL_W-1:0] data;
  } write_t;

  // All buffer writes caused by one pixel, in issue order, with the frame-end and overflow status.
  typedef struct packed {
    write_t [MAX_WR-1:0]   wr;
    logic [WR_IDX_W-1:0]   count;
    logic                  frame_done;
    logic [OFS_W-1:0]      length;
    logic                  overflow;
  } cmd_t;

endpackage

FILE: design/rgbrle_front.sv
// Front end: accepts pixels, tracks run and literal state, builds write commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgbrle_front #(
  parameter int MAX_SIDE   = 32,
  parameter int MAX_PACKET = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [23:0]          colour_i,
  input  logic                 last_i,
  output logic                 push_o,
  output rgbrle_pkg::cmd_t     cmd_o
);
  import rgbrle_pkg::*;

  localparam int BOUND = MAX_SIDE * MAX_SIDE;
  localparam int PIX_W = $clog2(BOUND + 1);

  logic [COL_W-1:0] held_colour_q, held_colour_d;
  logic [CNT_W-1:0] held_repeat_q, held_repeat_d;
  logic [CNT_W-1:0] lit_count_q, lit_count_d;
  logic [OFS_W-1:0] tag_slot_q, tag_slot_d;
  logic [OFS_W-1:0] next_ofs_q, next_ofs_d;
  logic [PIX_W-1:0] pix_count_q, pix_count_d;
  logic             ovf_q, ovf_d;

  logic [CNT_W-1:0]    lit_m1;
  logic [CNT_W-1:0]    rep_m1;
  logic [WR_IDX_W-1:0] n;
  write_t [MAX_WR-1:0] wr;

  always_comb begin
    held_colour_d = held_colour_q;
    held_repeat_d = held_repeat_q;
    lit_count_d   = lit_count_q;
    tag_slot_d    = tag_slot_q;
    next_ofs_d    = next_ofs_q;
    pix_count_d   = pix_count_q;
    ovf_d         = ovf_q;
    n             = '0;
    wr            = '0;
    lit_m1        = '0;
    rep_m1        = '0;

    if (pix_count_q >= PIX_W'(BOUND)) begin
      ovf_d = 1'b1;
    end else begin
      pix_count_d = pix_count_q + PIX_W'(1);
      if (held_repeat_q == '0) begin
        held_colour_d = colour_i;
        held_repeat_d = CNT_W'(1);
      end else if (colour_i == held_colour_q) begin
        held_repeat_d = held_repeat_q + CNT_W'(1);
        // second equal pixel starts a run: close the open literal span
        if (held_repeat_d == CNT_W'(2) && lit_count_d != '0) begin
          lit_m1 = lit_count_d - CNT_W'(1);
          wr[n] = '{offset: tag_slot_d, kind: KIND_TAG,
                    data: COL_W'({LIT_BIT, lit_m1[6:0]})};
          n = n + WR_IDX_W'(1);
          lit_count_d = '0;
        end
        if (held_repeat_d >= CNT_W'(MAX_PACKET)) begin
          rep_m1 = held_repeat_d - CNT_W'(1);
          wr[n] = '{offset: next_ofs_d, kind: KIND_TAG,
                    data: COL_W'({RUN_BIT, rep_m1[6:0]})};
          n = n + WR_IDX_W'(1);
          next_ofs_d = next_ofs_d + OFS_W'(1);
          wr[n] = '{offset: next_ofs_d, kind: KIND_COLOUR, data: held_colour_d};
          n = n + WR_IDX_W'(1);
          next_ofs_d = next_ofs_d + OFS_W'(3);
          held_repeat_d = '0;
        end
      end else begin
        if (held_repeat_q >= CNT_W'(2)) begin
          rep_m1 = held_repeat_q - CNT_W'(1);
          wr[n] = '{offset: next_ofs_d, kind: KIND_TAG,
                    data: COL_W'({RUN_BIT, rep_m1[6:0]})};
          n = n + WR_IDX_W'(1);
          next_ofs_d = next_ofs_d + OFS_W'(1);
          wr[n] = '{offset: next_ofs_d, kind: KIND_COLOUR, data: held_colour_q};
          n = n + WR_IDX_W'(1);
          next_ofs_d = next_ofs_d + OFS_W'(3);
        end else begin
          // reserve the tag slot when a literal span opens
          if (lit_count_d == '0) begin
            tag_slot_d = next_ofs_d;
            next_ofs_d = next_ofs_d + OFS_W'(1);
          end
          wr[n] = '{offset: next_ofs_d, kind: KIND_COLOUR, data: held_colour_q};
          n = n + WR_IDX_W'(1);
          next_ofs_d = next_ofs_d + OFS_W'(3);
          lit_count_d = lit_count_d + CNT_W'(1);
          if (lit_count_d >= CNT_W'(MAX_PACKET)) begin
            lit_m1 = lit_count_d - CNT_W'(1);
            wr[n] = '{offset: tag_slot_d, kind: KIND_TAG,
                      data: COL_W'({LIT_BIT, lit_m1[6:0]})};
            n = n + WR_IDX_W'(1);
            lit_count_d = '0;
          end
        end
        held_colour_d = colour_i;
        held_repeat_d = CNT_W'(1);
      end
    end

    if (last_i) begin
      // flush whatever is pending
      if (held_repeat_d >= CNT_W'(2)) begin
        rep_m1 = held_repeat_d - CNT_W'(1);
        wr[n] = '{offset: next_ofs_d, kind: KIND_TAG,
                  data: COL_W'({RUN_BIT, rep_m1[6:0]})};
        n = n + WR_IDX_W'(1);
        next_ofs_d = next_ofs_d + OFS_W'(1);
        wr[n] = '{offset: next_ofs_d, kind: KIND_COLOUR, data: held_colour_d};
        n = n + WR_IDX_W'(1);
        next_ofs_d = next_ofs_d + OFS_W'(3);
      end else if (held_repeat_d == CNT_W'(1)) begin
        if (lit_count_d == '0) begin
          tag_slot_d = next_ofs_d;
          next_ofs_d = next_ofs_d + OFS_W'(1);
        end
        wr[n] = '{offset: next_ofs_d, kind: KIND_COLOUR, data: held_colour_d};
        n = n + WR_IDX_W'(1);
        next_ofs_d = next_ofs_d + OFS_W'(3);
        lit_count_d = lit_count_d + CNT_W'(1);
        if (lit_count_d >= CNT_W'(MAX_PACKET)) begin
          lit_m1 = lit_count_d - CNT_W'(1);
          wr[n] = '{offset: tag_slot_d, kind: KIND_TAG,
                    data: COL_W'({LIT_BIT, lit_m1[6:0]})};
          n = n + WR_IDX_W'(1);
          lit_count_d = '0;
        end
      end
      if (lit_count_d != '0) begin
        lit_m1 = lit_count_d - CNT_W'(1);
        wr[n] = '{offset: tag_slot_d, kind: KIND_TAG,
                  data: COL_W'({LIT_BIT, lit_m1[6:0]})};
        n = n + WR_IDX_W'(1);
      end
      // dropped final pixel with nothing pending: emit a pad marker
      if (n == '0) begin
        wr[n] = '{offset: next_ofs_d, kind: KIND_TAG, data: '0};
        n = n + WR_IDX_W'(1);
      end
    end
  end

  assign cmd_o.wr         = wr;
  assign cmd_o.count      = n;
  assign cmd_o.frame_done = last_i;
  assign cmd_o.length     = next_ofs_d;
  assign cmd_o.overflow   = ovf_d;
  assign push_o           = accept_i && (n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_colour_q <= '0;
      held_repeat_q <= '0;
      lit_count_q   <= '0;
      tag_slot_q    <= '0;
      next_ofs_q    <= '0;
      pix_count_q   <= '0;
      ovf_q         <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        held_colour_q <= '0;
        held_repeat_q <= '0;
        lit_count_q   <= '0;
        tag_slot_q    <= '0;
        next_ofs_q    <= '0;
        pix_count_q   <= '0;
        ovf_q         <= 1'b0;
      end else begin
        held_colour_q <= held_colour_d;
        held_repeat_q <= held_repeat_d;
        lit_count_q   <= lit_count_d;
        tag_slot_q    <= tag_slot_d;
        next_ofs_q    <= next_ofs_d;
        pix_count_q   <= pix_count_d;
        ovf_q         <= ovf_d;
      end
    end
  end

  `ASSERT_ALWAYS(a_frame_end_clears, accept_i && last_i |=> next_ofs_q == '0 && pix_count_q == '0, "frame state not cleared after frame end")
  `ASSERT_ALWAYS(a_frame_end_writes, accept_i && last_i |-> push_o, "frame end produced no write")
  `ASSERT_NEVER(a_lit_span_bound, lit_count_q >= CNT_W'(MAX_PACKET) && held_repeat_q != '0, "literal span past packet limit")

endmodule

FILE: design/rgbrle_fifo.sv
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgbrle_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rgbrle_pkg::cmd_t  cmd_i,
  output logic              full_o,
  output logic              valid_o,
  output rgbrle_pkg::cmd_t  cmd_o,
  input  logic              pop_i
);
  import rgbrle_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `ASSERT_NEVER(a_push_full, push_i && full_o, "push into full queue")
  `ASSERT_NEVER(a_pop_empty, pop_i && !valid_o, "pop from empty queue")

endmodule

FILE: design/rgbrle_back.sv
// Back end: issues the writes of each queued command, one per cycle while the consumer is ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rgbrle_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  rgbrle_pkg::cmd_t  cmd_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output rgbrle_pkg::write_t wr_o,
  output logic              frame_done_o,
  output logic [11:0]       length_o,
  output logic              overflow_o
);
  import rgbrle_pkg::*;

  logic [WR_IDX_W-1:0] idx_q, idx_d;
  logic                valid_q, valid_d;
  write_t              wr_q;
  logic                done_q;
  logic [OFS_W-1:0]    len_q;
  logic                ovf_q;
  logic                load;
  logic                final_wr;

  assign load     = cmd_valid_i && (!valid_q || ready_i);
  assign final_wr = (idx_q == cmd_i.count - WR_IDX_W'(1));
  assign pop_o    = load && final_wr;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = final_wr ? '0 : idx_q + WR_IDX_W'(1);
    end
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // hold the payload while the consumer stalls
  always_ff @(posedge clk_i) begin
    if (load) begin
      wr_q   <= cmd_i.wr[idx_q];
      done_q <= final_wr && cmd_i.frame_done;
      len_q  <= (final_wr && cmd_i.frame_done) ? cmd_i.length : '0;
      ovf_q  <= cmd_i.overflow;
    end
  end

  assign valid_o      = valid_q;
  assign wr_o         = wr_q;
  assign frame_done_o = done_q;
  assign length_o     = len_q;
  assign overflow_o   = ovf_q;

  `ASSERT_ALWAYS(a_idx_in_cmd, cmd_valid_i |-> idx_q < cmd_i.count, "write index past command")
  `ASSERT_ALWAYS(a_pop_restarts, pop_o |=> idx_q == '0, "index not rewound after command")

endmodule

FILE: design/rgb_packbits_rle_encoder_unit.sv
// Rate: the front end takes one pixel per cycle and turns it into a command of
// zero to four buffer writes; the back end issues those writes one per cycle
// while the output is ready, through a single registered output port. A pixel
// causes at most four writes, typically zero or one inside runs and literal
// spans. The two-entry command queue between the ends lets pixels keep flowing
// while earlier writes drain, and the input stalls only while both queue entries
// are occupied. Pixels past MAX_SIDE*MAX_SIDE in a frame are dropped and flag
// overflow; tlast on the input flushes the frame, and tlast on the output marks
// its final write.
`timescale 1ns / 1ps
module rgb_packbits_rle_encoder_unit #(
  parameter int MAX_SIDE   = 32,
  parameter int MAX_PACKET = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // red [7:0], green [15:8], blue [23:16]
  input  logic        s_axis_tlast_i,   // last_pixel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // write_offset [11:0], write_data [35:12], encoded_length [47:36],
  // overflow [48], zero [55:49]
  output logic [55:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // write_kind
  output logic        m_axis_tlast_o    // frame_done
);
  import rgbrle_pkg::*;

  logic   accept;
  logic   push;
  cmd_t   front_cmd;
  logic   fifo_full;
  logic   fifo_valid;
  cmd_t   head_cmd;
  logic   pop;
  write_t out_wr;
  logic   out_done;
  logic [OFS_W-1:0] out_len;
  logic   out_ovf;
  logic [COL_W-1:0] colour;

  assign s_axis_tready_o = !fifo_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign colour          = {s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tdata_i[23:16]};

  rgbrle_front #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_PACKET (MAX_PACKET)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .colour_i (colour),
    .last_i   (s_axis_tlast_i),
    .push_o   (push),
    .cmd_o    (front_cmd)
  );

  rgbrle_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .cmd_o   (head_cmd),
    .pop_i   (pop)
  );

  rgbrle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (fifo_valid),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .wr_o         (out_wr),
    .frame_done_o (out_done),
    .length_o     (out_len),
    .overflow_o   (out_ovf)
  );

  assign m_axis_tdata_o = {7'd0, out_ovf, out_len, out_wr.data, out_wr.offset};
  assign m_axis_tuser_o = out_wr.kind;
  assign m_axis_tlast_o = out_done;

endmodule
